@@ rtl/brt_pkg.sv @@
// Shared types, codes and sizes for the box region table.
`timescale 1ns / 1ps

package brt_pkg;

   // Table geometry
   localparam int ENTRIES    = 16;
   localparam int COORD_BITS = 24;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SLOT_BITS  = 4;
   localparam int TOL_BITS   = 8;
   localparam int CSR_BITS   = 8;

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } corner_type;

   typedef struct packed {
      logic veh;
      logic peds;
      logic cancel;
      logic valid;
   } flags_type;

   typedef enum logic [1:0] {
      KIND_ADD          = 2'd0,
      KIND_REMOVE       = 2'd1,
      KIND_BLOCK_QUERY  = 2'd2,
      KIND_CANCEL_QUERY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_DUP  = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_REJECT_DUP = 1'b0,
      CSR_DUP_TOL    = 1'b1
   } csr_idx_type;

   // Controller -> datapath
   typedef struct packed {
      logic                start;    // input transaction accepted, latch fields
      logic                rd_en;    // read one table row
      logic [IDX_BITS-1:0] rd_addr;
      logic                commit;   // update table and load the response
   } brt_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic out_free;                // response register can take a result
   } brt_stat_type;

endpackage

@@ rtl/brt_ctrl.sv @@
// Sequencer for the box region table: accept, row scan, drain, commit.
`timescale 1ns / 1ps

module brt_ctrl
   import brt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [1:0]   req_kind,
   output logic         req_ready,
   input  brt_stat_type stat,
   output brt_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_BITS-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd.start   = 1'b0;
      cmd.rd_en   = 1'b0;
      cmd.rd_addr = cnt_ff;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd.start = 1'b1;
               // remove needs no scan
               if (kind_type'(req_kind) == KIND_REMOVE) begin
                  state_in = ST_COMMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ rtl/brt_dp.sv @@
// Datapath for the box region table: corner memories, flags, compares, response.
`timescale 1ns / 1ps

module brt_dp
   import brt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  brt_cmd_type          cmd,
   output brt_stat_type         stat,
   // input fields
   input  logic [1:0]           req_kind,
   input  coord_type            req_min_x,
   input  coord_type            req_min_y,
   input  coord_type            req_min_z,
   input  coord_type            req_max_x,
   input  coord_type            req_max_y,
   input  coord_type            req_max_z,
   input  logic                 req_cancel_flag,
   input  logic                 req_ped_flag,
   input  logic                 req_vehicle_flag,
   input  logic [SLOT_BITS-1:0] req_slot_id,
   // configuration
   input  logic                 csr_write_en,
   input  logic [0:0]           csr_index,
   input  logic [CSR_BITS-1:0]  csr_wdata,
   // response
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [SLOT_BITS-1:0] rsp_slot_out,
   output logic                 rsp_hit
);

   localparam int DIFF_BITS = COORD_BITS + 1;

   // latched transaction
   kind_type             kind_ff, kind_in;
   corner_type           pa_ff, pa_in;   // min corner / query point
   corner_type           pb_ff, pb_in;
   logic                 cf_ff, cf_in;
   logic                 pf_ff, pf_in;
   logic                 vf_ff, vf_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;

   // configuration
   logic                 reject_ff, reject_in;
   logic [TOL_BITS-1:0]  tol_ff, tol_in;

   // table
   corner_type           lo_mem [ENTRIES];
   corner_type           hi_mem [ENTRIES];
   flags_type            flags_ff [ENTRIES];
   flags_type            flags_in [ENTRIES];

   corner_type           rd_lo_ff, rd_hi_ff;
   logic                 rd_vld_ff;
   logic [IDX_BITS-1:0]  rd_idx_ff;

   // scan results
   logic                 dup_ff, dup_in;
   logic                 hit_ff, hit_in;
   logic                 free_ok_ff, free_ok_in;
   logic [IDX_BITS-1:0]  free_idx_ff, free_idx_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [SLOT_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   logic                 rsp_hit_ff, rsp_hit_in;

   flags_type            cur_flags;
   logic                 close_all, inside_pt, match, cancel_ok;
   logic                 mem_we;
   corner_type           ord_lo, ord_hi;

   function automatic logic near_coord(coord_type a, coord_type b,
                                       logic [TOL_BITS-1:0] tol);
      logic signed [DIFF_BITS-1:0] d;
      logic        [DIFF_BITS-1:0] m;
      d = DIFF_BITS'(a) - DIFF_BITS'(b);
      m = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
      return m <= {{(DIFF_BITS-TOL_BITS){1'b0}}, tol};
   endfunction

   function automatic coord_type min_c(coord_type a, coord_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic coord_type max_c(coord_type a, coord_type b);
      return (a < b) ? b : a;
   endfunction

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // ---- transaction latch and configuration
   always_comb begin
      kind_in   = kind_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      cf_in     = cf_ff;
      pf_in     = pf_ff;
      vf_in     = vf_ff;
      slot_in   = slot_ff;
      reject_in = reject_ff;
      tol_in    = tol_ff;
      if (cmd.start) begin
         kind_in = kind_type'(req_kind);
         pa_in   = '{x: req_min_x, y: req_min_y, z: req_min_z};
         pb_in   = '{x: req_max_x, y: req_max_y, z: req_max_z};
         cf_in   = req_cancel_flag;
         pf_in   = req_ped_flag;
         vf_in   = req_vehicle_flag;
         slot_in = req_slot_id;
      end
      if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_REJECT_DUP: reject_in = csr_wdata[0];
            CSR_DUP_TOL:    tol_in    = csr_wdata[TOL_BITS-1:0];
            default:        reject_in = reject_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      cf_ff   <= cf_in;
      pf_ff   <= pf_in;
      vf_ff   <= vf_in;
      slot_ff <= slot_in;
      if (reset) begin
         reject_ff <= 1'b0;
         tol_ff    <= TOL_BITS'(2);
      end else begin
         reject_ff <= reject_in;
         tol_ff    <= tol_in;
      end
   end

   // ---- corner memories: one write port, one registered read port
   assign ord_lo = '{x: min_c(pa_ff.x, pb_ff.x), y: min_c(pa_ff.y, pb_ff.y),
                     z: min_c(pa_ff.z, pb_ff.z)};
   assign ord_hi = '{x: max_c(pa_ff.x, pb_ff.x), y: max_c(pa_ff.y, pb_ff.y),
                     z: max_c(pa_ff.z, pb_ff.z)};
   assign mem_we = cmd.commit && (kind_ff == KIND_ADD) && !dup_ff && free_ok_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lo_mem[free_idx_ff] <= ord_lo;
         hi_mem[free_idx_ff] <= ord_hi;
      end
      if (cmd.rd_en) begin
         rd_lo_ff <= lo_mem[cmd.rd_addr];
         rd_hi_ff <= hi_mem[cmd.rd_addr];
      end
      rd_idx_ff <= cmd.rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
      end
   end

   // ---- per-row evaluation
   assign cur_flags = flags_ff[rd_idx_ff];

   assign close_all = near_coord(rd_lo_ff.x, pa_ff.x, tol_ff) &&
                      near_coord(rd_lo_ff.y, pa_ff.y, tol_ff) &&
                      near_coord(rd_lo_ff.z, pa_ff.z, tol_ff) &&
                      near_coord(rd_hi_ff.x, pb_ff.x, tol_ff) &&
                      near_coord(rd_hi_ff.y, pb_ff.y, tol_ff) &&
                      near_coord(rd_hi_ff.z, pb_ff.z, tol_ff);

   // inclusive bounds
   assign inside_pt = (pa_ff.x >= rd_lo_ff.x) && (pa_ff.x <= rd_hi_ff.x) &&
                      (pa_ff.y >= rd_lo_ff.y) && (pa_ff.y <= rd_hi_ff.y) &&
                      (pa_ff.z >= rd_lo_ff.z) && (pa_ff.z <= rd_hi_ff.z);

   assign match     = (cur_flags.peds && pf_ff) || (cur_flags.veh && vf_ff);
   assign cancel_ok = (kind_ff != KIND_CANCEL_QUERY) || cur_flags.cancel;

   always_comb begin
      dup_in      = dup_ff;
      hit_in      = hit_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      if (cmd.start) begin
         dup_in     = 1'b0;
         hit_in     = 1'b0;
         free_ok_in = 1'b0;
      end else if (rd_vld_ff) begin
         if (kind_ff == KIND_ADD) begin
            if (reject_ff && cur_flags.valid && close_all) begin
               dup_in = 1'b1;
            end
            // lowest free row wins
            if (!cur_flags.valid && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = rd_idx_ff;
            end
         end else if (cur_flags.valid && match && cancel_ok && inside_pt) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dup_ff      <= dup_in;
      hit_ff      <= hit_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
   end

   // ---- entry flags
   always_comb begin
      for (int e = 0; e < ENTRIES; e++) begin
         flags_in[e] = flags_ff[e];
         if (cmd.commit && (kind_ff == KIND_REMOVE) && (32'(slot_ff) == e)) begin
            flags_in[e] = '0;
         end
         if (mem_we && (32'(free_idx_ff) == e)) begin
            flags_in[e] = '{veh: vf_ff, peds: pf_ff, cancel: cf_ff, valid: 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < ENTRIES; e++) begin
         if (reset) begin
            flags_ff[e] <= '0;
         end else begin
            flags_ff[e] <= flags_in[e];
         end
      end
   end

   // ---- response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_hit_in    = rsp_hit_ff;
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STAT_OK;
         rsp_slot_in   = '0;
         rsp_hit_in    = hit_ff;
         if (kind_ff == KIND_ADD) begin
            if (dup_ff) begin
               rsp_status_in = STAT_DUP;
            end else if (free_ok_ff) begin
               rsp_slot_in = SLOT_BITS'(free_idx_ff);
            end else begin
               rsp_status_in = STAT_FULL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hit_ff    <= rsp_hit_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_hit      = rsp_hit_ff;

endmodule

@@ rtl/box_region_table.sv @@
// Top level of the box region table: controller, datapath and checks.
`timescale 1ns / 1ps

// Box region table. Holds up to ENTRIES (16) axis-aligned boxes in signed
// 1/16-unit fixed point, each with valid, cancel, pedestrian and vehicle
// flags. A request transaction is one of: add (corners ordered per axis,
// stored in the lowest free slot, optionally refused when a valid box lies
// within dup_tolerance on every corner coordinate), remove (clears one slot,
// out-of-range slots ignored), blocked query and cancel query (hit when a
// valid box that blocks a selected entity type contains the point, bounds
// inclusive; the cancel query also needs the cancel flag). Every request
// yields exactly one response transaction. Add and both queries scan every
// row: the corner memories have one read port, so the scan reads one row
// per cycle, followed by a drain state for the registered read and a commit
// state that updates the table and loads the response register. Remove
// skips the scan and goes straight to commit. Only one request is in
// flight; the response register holds a finished result while the next
// request is accepted, and the commit waits only if that register is still
// full. Corner storage has no reset; of the table, only the per-slot flags
// are cleared by reset. Configuration writes are registered on csr_write_en
// and must only occur while the block is idle.

module box_region_table
   import brt_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_kind,
   input  logic signed [COORD_BITS-1:0] req_min_x,
   input  logic signed [COORD_BITS-1:0] req_min_y,
   input  logic signed [COORD_BITS-1:0] req_min_z,
   input  logic signed [COORD_BITS-1:0] req_max_x,
   input  logic signed [COORD_BITS-1:0] req_max_y,
   input  logic signed [COORD_BITS-1:0] req_max_z,
   input  logic                         req_cancel_flag,
   input  logic                         req_ped_flag,
   input  logic                         req_vehicle_flag,
   input  logic [SLOT_BITS-1:0]         req_slot_id,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [SLOT_BITS-1:0]         rsp_slot_out,
   output logic                         rsp_hit,
   // configuration writes
   input  logic                         csr_write_en,
   input  logic [0:0]                   csr_index,
   input  logic [CSR_BITS-1:0]          csr_wdata
);

   brt_cmd_type  cmd;
   brt_stat_type stat;

   // sequencing: idle -> scan rows -> drain -> commit; remove skips to commit
   brt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, compares and the response register
   brt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_min_x        (req_min_x),
      .req_min_y        (req_min_y),
      .req_min_z        (req_min_z),
      .req_max_x        (req_max_x),
      .req_max_y        (req_max_y),
      .req_max_z        (req_max_z),
      .req_cancel_flag  (req_cancel_flag),
      .req_ped_flag     (req_ped_flag),
      .req_vehicle_flag (req_vehicle_flag),
      .req_slot_id      (req_slot_id),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_hit          (rsp_hit)
   );

   // One request in flight: acceptance always leaves the idle state.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   // A query hit never carries add status or a slot number.
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_status == STAT_OK && rsp_slot_out == '0))
      else $error("hit response with non-zero status or slot");

   // A refused or failed add reports slot zero.
   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> (rsp_slot_out == '0 && !rsp_hit))
      else $error("failed add reports a slot or a hit");

endmodule
